### sv/lkx_pkg.sv
package lkx_pkg;

    localparam int LKX_QDEPTH = 2;

    localparam int BYTE_W    = 8;
    localparam int MULT_W    = 16;
    localparam int INC_W     = 16;
    localparam int MOD_W     = 17;
    localparam int CFG_W     = 17;
    localparam int CFG_IDX_W = 2;
    localparam int ACC_W     = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_SEED       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MULTIPLIER = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INCREMENT  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MODULUS    = 2'd3;

    localparam logic [MOD_W-1:0] MOD_RESET = 17'd256;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
        logic              first;
    } t_item;

    typedef struct packed {
        logic [BYTE_W-1:0] seed;
        logic [MULT_W-1:0] multiplier;
        logic [INC_W-1:0]  increment;
        logic [MOD_W-1:0]  modulus;
    } t_cfg;

endpackage

### sv/lkx_front.sv
module lkx_front #(
    parameter int P_QDEPTH = lkx_pkg::LKX_QDEPTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [lkx_pkg::BYTE_W-1:0] i_data_byte,
    input  logic                       i_last_byte,
    output logic                       o_q_valid,
    output lkx_pkg::t_item             o_q_item,
    input  logic                       i_q_pop
);
    import lkx_pkg::*;

    localparam int PTR_W = (P_QDEPTH > 1) ? $clog2(P_QDEPTH) : 1;
    localparam int CNT_W = $clog2(P_QDEPTH + 1);

    t_item            r_mem [P_QDEPTH];
    logic [PTR_W-1:0] r_wptr, n_wptr;
    logic [PTR_W-1:0] r_rptr, n_rptr;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_first, n_first;
    logic             push, pop;
    t_item            wr_item;

    assign o_in_ready = (r_cnt != CNT_W'(P_QDEPTH));
    assign o_q_valid  = (r_cnt != '0);
    assign o_q_item   = r_mem[r_rptr];

    assign push = i_in_valid && o_in_ready;
    assign pop  = i_q_pop && o_q_valid;

    // tag each word with whether it opens a message
    always_comb begin
        wr_item.data  = i_data_byte;
        wr_item.last  = i_last_byte;
        wr_item.first = r_first;
    end

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_cnt   = r_cnt;
        n_first = r_first;
        if (push) begin
            n_wptr  = (r_wptr == PTR_W'(P_QDEPTH - 1)) ? '0 : r_wptr + 1'b1;
            n_first = i_last_byte;
        end
        if (pop) begin
            n_rptr = (r_rptr == PTR_W'(P_QDEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (push && !pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (pop && !push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_cnt   <= '0;
            r_first <= 1'b1;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_cnt   <= n_cnt;
            r_first <= n_first;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= wr_item;
        end
    end

endmodule

### sv/lkx_back.sv
module lkx_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  lkx_pkg::t_cfg              i_cfg,
    input  logic                       i_q_valid,
    input  lkx_pkg::t_item             i_q_item,
    output logic                       o_q_pop,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [lkx_pkg::BYTE_W-1:0] o_result_byte,
    output logic                       o_result_last
);
    import lkx_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MUL  = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    localparam int STEP_W = $clog2(ACC_W);

    logic [1:0]        r_state, n_state;
    logic [BYTE_W-1:0] r_data, n_data;
    logic              r_last, n_last;
    logic [BYTE_W-1:0] r_key, n_key;
    logic [ACC_W-1:0]  r_acc, n_acc;
    logic [MOD_W-1:0]  r_rem, n_rem;
    logic [STEP_W-1:0] r_step, n_step;
    logic              r_out_valid, n_out_valid;
    logic [BYTE_W-1:0] r_out_byte, n_out_byte;
    logic              r_out_last, n_out_last;

    logic [ACC_W-1:0]  lcg_sum;
    logic [MOD_W:0]    rem_shift;
    logic [MOD_W:0]    rem_diff;
    logic [MOD_W-1:0]  rem_next;
    logic              out_free;

    assign o_out_valid   = r_out_valid;
    assign o_result_byte = r_out_byte;
    assign o_result_last = r_out_last;

    assign out_free = !r_out_valid || i_out_ready;
    assign o_q_pop  = (r_state == S_IDLE) && i_q_valid;

    // 16x8 product plus increment fits in 24 bits
    assign lcg_sum = ACC_W'(i_cfg.multiplier) * ACC_W'(r_key) + ACC_W'(i_cfg.increment);

    // restoring remainder, one dividend bit per cycle
    assign rem_shift = {r_rem, r_acc[ACC_W-1]};
    assign rem_diff  = rem_shift - {1'b0, i_cfg.modulus};
    assign rem_next  = (rem_shift >= {1'b0, i_cfg.modulus}) ? rem_diff[MOD_W-1:0]
                                                            : rem_shift[MOD_W-1:0];

    always_comb begin
        n_state     = r_state;
        n_data      = r_data;
        n_last      = r_last;
        n_key       = r_key;
        n_acc       = r_acc;
        n_rem       = r_rem;
        n_step      = r_step;
        n_out_valid = r_out_valid;
        n_out_byte  = r_out_byte;
        n_out_last  = r_out_last;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    n_data = i_q_item.data;
                    n_last = i_q_item.last;
                    if (i_q_item.first) begin
                        n_key   = i_cfg.seed;
                        n_state = S_DONE;
                    end else begin
                        n_state = S_MUL;
                    end
                end
            end
            S_MUL: begin
                if (i_cfg.modulus == '0) begin
                    n_key   = lcg_sum[BYTE_W-1:0];
                    n_state = S_DONE;
                end else begin
                    n_acc   = lcg_sum;
                    n_rem   = '0;
                    n_step  = '0;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                n_rem  = rem_next;
                n_acc  = {r_acc[ACC_W-2:0], 1'b0};
                n_step = r_step + 1'b1;
                if (r_step == STEP_W'(ACC_W - 1)) begin
                    n_key   = rem_next[BYTE_W-1:0];
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = r_data ^ r_key;
                    n_out_last  = r_last;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data     <= n_data;
        r_last     <= n_last;
        r_key      <= n_key;
        r_acc      <= n_acc;
        r_rem      <= n_rem;
        r_step     <= n_step;
        r_out_byte <= n_out_byte;
        r_out_last <= n_out_last;
    end

endmodule

### sv/lcg_keystream_xor_cipher_core.sv
// LCG keystream XOR cipher core.
// Input channel (i_in_valid/o_in_ready) takes one word per handshake: a data
// byte and a last-byte flag. Output channel (o_out_valid/i_out_ready) returns
// the byte XORed with the keystream byte, plus a copy of the flag.
// The first word of a message uses the seed register as keystream byte; each
// later byte is (multiplier * previous + increment) mod modulus, low 8 bits,
// with a zero modulus meaning no reduction. A word with the last flag set ends
// the message; the next word restarts from the seed.
// Configuration: write i_cfg_data to register i_cfg_idx (0 seed, 1 multiplier,
// 2 increment, 3 modulus) while i_cfg_we is high, only while the core is idle.
// Path: a message's first word goes from the queue through the idle and done
// states into the result register; later words also pass a multiply state and
// the bit-serial remainder unit over the 24-bit product, skipped with a zero
// modulus. The back end takes no new word until the current one is through.
// A small input queue takes words while the back end works, until it is full;
// the result register holds a word until taken; the back end waits on a stall.
// Reset clears the queue and output valid, restores register defaults
// (modulus 256, others 0) and makes the next word start a message.
module lcg_keystream_xor_cipher_core #(
    parameter int P_QDEPTH = lkx_pkg::LKX_QDEPTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [lkx_pkg::BYTE_W-1:0]    i_data_byte,
    input  logic                          i_last_byte,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [lkx_pkg::BYTE_W-1:0]    o_result_byte,
    output logic                          o_result_last,
    input  logic                          i_cfg_we,
    input  logic [lkx_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [lkx_pkg::CFG_W-1:0]     i_cfg_data
);
    import lkx_pkg::*;

    t_cfg  r_cfg, n_cfg;
    logic  q_valid;
    logic  q_pop;
    t_item q_item;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SEED:       n_cfg.seed       = i_cfg_data[BYTE_W-1:0];
                CFG_MULTIPLIER: n_cfg.multiplier = i_cfg_data[MULT_W-1:0];
                CFG_INCREMENT:  n_cfg.increment  = i_cfg_data[INC_W-1:0];
                CFG_MODULUS:    n_cfg.modulus    = i_cfg_data[MOD_W-1:0];
                default:        n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.seed       <= '0;
            r_cfg.multiplier <= '0;
            r_cfg.increment  <= '0;
            r_cfg.modulus    <= MOD_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    lkx_front #(
        .P_QDEPTH(P_QDEPTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .o_q_valid   (q_valid),
        .o_q_item    (q_item),
        .i_q_pop     (q_pop)
    );

    lkx_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_q_valid     (q_valid),
        .i_q_item      (q_item),
        .o_q_pop       (q_pop),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_result_byte (o_result_byte),
        .o_result_last (o_result_last)
    );

endmodule
